[rtl/rbd_pkg.sv]
// Package for the ring buffer deque: constants, operation codes and item types.
package rbd_pkg;

    localparam int CAPACITY = 1024;
    localparam int PTR_W    = $clog2(CAPACITY);
    localparam int COUNT_W  = 11;
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    localparam logic signed [DATA_W-1:0] NEG_ONE = -32'sd1;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] push_value;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] popped_value;
        logic [STATUS_W-1:0]      status;
        logic [COUNT_W-1:0]       count;
        logic                     is_empty;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] back_value;
    } out_item_t;

    typedef enum logic {
        S_IDLE,
        S_POP_WAIT
    } ctrl_state_t;

    typedef struct packed {
        logic take;
        logic finish_pop;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic pop_hit;
    } dp_status_t;

endpackage

[rtl/rbd_ctrl.sv]
// Controller for the ring buffer deque: handshakes, pop read wait and output slot.
module rbd_ctrl
    import rbd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t dp_status,
    output ctrl_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        slot_free;

    assign slot_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid && slot_free && dp_status.pop_hit) begin
                    state_next = S_POP_WAIT;
                end
            end
            S_POP_WAIT: begin
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready        = 1'b0;
        cmd.take       = 1'b0;
        cmd.finish_pop = 1'b0;
        cmd.load_out   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready      = slot_free;
                cmd.take     = s_valid && slot_free;
                cmd.load_out = s_valid && slot_free && !dp_status.pop_hit;
            end
            S_POP_WAIT: begin
                cmd.finish_pop = 1'b1;
                cmd.load_out   = 1'b1;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_pop_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.take && dp_status.pop_hit) |=> (state_reg == S_POP_WAIT))
        else $error("pop item did not enter the read wait");
    a_wait_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_POP_WAIT) |=> (state_reg == S_IDLE))
        else $error("read wait lasted more than one cycle");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!out_valid_reg || m_ready))
        else $error("output item overwritten before it was taken");
`endif

endmodule

[rtl/rbd_dp.sv]
// Datapath for the ring buffer deque: entry store, pointers, count and end caches.
module rbd_dp
    import rbd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  ctrl_cmd_t  cmd,
    input  in_item_t   s_item,
    output out_item_t  m_item,
    output dp_status_t dp_status
);

    logic signed [DATA_W-1:0] mem [CAPACITY];

    logic [PTR_W-1:0]         head_reg, head_next;
    logic [PTR_W-1:0]         tail_reg, tail_next;
    logic [COUNT_W-1:0]       count_reg, count_next;
    logic signed [DATA_W-1:0] front_reg, front_next;
    logic signed [DATA_W-1:0] back_reg, back_next;
    logic signed [DATA_W-1:0] pend_popped_reg;
    logic                     pend_back_reg;
    logic signed [DATA_W-1:0] rd_data_reg;
    out_item_t                out_reg, out_next;

    logic                     wr_en, rd_en;
    logic [PTR_W-1:0]         wr_addr, rd_addr;
    logic                     is_push, is_pop, is_empty, is_full;

    function automatic logic [PTR_W-1:0] step_up(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(CAPACITY - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] step_down(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(CAPACITY - 1) : p - PTR_W'(1);
    endfunction

    assign is_push  = (s_item.op == OP_PUSH_FRONT) || (s_item.op == OP_PUSH_BACK);
    assign is_pop   = (s_item.op == OP_POP_FRONT) || (s_item.op == OP_POP_BACK);
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == COUNT_W'(CAPACITY));

    assign dp_status.pop_hit = is_pop && !is_empty;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        front_next = front_reg;
        back_next  = back_reg;
        wr_en      = 1'b0;
        wr_addr    = tail_reg;
        rd_en      = 1'b0;
        rd_addr    = step_up(head_reg);
        out_next   = out_reg;

        if (cmd.take) begin
            out_next.popped_value = NEG_ONE;
            out_next.status       = STATUS_OK;
            if (is_push && is_full) begin
                out_next.status = STATUS_FULL;
            end else if (is_pop && is_empty) begin
                out_next.status = STATUS_EMPTY;
            end else if (s_item.op == OP_PUSH_FRONT) begin
                head_next  = step_down(head_reg);
                wr_en      = 1'b1;
                wr_addr    = step_down(head_reg);
                count_next = count_reg + COUNT_W'(1);
                front_next = s_item.push_value;
                back_next  = is_empty ? s_item.push_value : back_reg;
            end else if (s_item.op == OP_PUSH_BACK) begin
                tail_next  = step_up(tail_reg);
                wr_en      = 1'b1;
                wr_addr    = tail_reg;
                count_next = count_reg + COUNT_W'(1);
                back_next  = s_item.push_value;
                front_next = is_empty ? s_item.push_value : front_reg;
            end else if (s_item.op == OP_POP_FRONT) begin
                head_next  = step_up(head_reg);
                rd_en      = 1'b1;
                rd_addr    = step_up(head_reg);
                count_next = count_reg - COUNT_W'(1);
            end else if (s_item.op == OP_POP_BACK) begin
                tail_next  = step_down(tail_reg);
                rd_en      = 1'b1;
                rd_addr    = step_down(step_down(tail_reg));
                count_next = count_reg - COUNT_W'(1);
            end
            out_next.count       = count_next;
            out_next.is_empty    = (count_next == '0);
            out_next.front_value = (count_next == '0) ? NEG_ONE : front_next;
            out_next.back_value  = (count_next == '0) ? NEG_ONE : back_next;
        end else if (cmd.finish_pop) begin
            if (pend_back_reg) begin
                back_next = rd_data_reg;
            end else begin
                front_next = rd_data_reg;
            end
            out_next.popped_value = pend_popped_reg;
            out_next.status       = STATUS_OK;
            out_next.count        = count_reg;
            out_next.is_empty     = is_empty;
            out_next.front_value  = is_empty ? NEG_ONE : front_next;
            out_next.back_value   = is_empty ? NEG_ONE : back_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= s_item.push_value;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        front_reg <= front_next;
        back_reg  <= back_next;
        if (cmd.load_out) begin
            out_reg <= out_next;
        end
        if (cmd.take) begin
            pend_back_reg   <= (s_item.op == OP_POP_BACK);
            pend_popped_reg <= (s_item.op == OP_POP_BACK) ? back_reg : front_reg;
        end
    end

    assign m_item = out_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(CAPACITY))
        else $error("entry count above capacity");
    a_empty_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == '0) |-> (head_reg == tail_reg))
        else $error("pointers differ on an empty queue");
    a_full_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.take && is_push && is_full) |=> ($stable(count_reg) && $stable(head_reg)
            && $stable(tail_reg)))
        else $error("rejected push changed the queue");
`endif

endmodule

[rtl/ring_buffer_deque.sv]
// Top level of the ring buffer deque: controller and datapath.
//
// Double-ended queue of CAPACITY signed 32-bit entries in a circular store.
// Input channel s_valid/s_ready/s_item carries an operation code and a push
// value; result channel m_valid/m_ready/m_item returns one item per input:
// popped value, status, count, empty flag and the front and back entries.
// Pushes, queries and pops on an empty queue: the result is registered at the
// edge the item is taken, and the next item may follow in the next cycle.
// A successful pop goes through the read wait state: the entry store has one
// registered read port, and the new front or back entry is read from it before
// the result is built. Front and back entries are otherwise held in registers.
// Reset (aresetn low, synchronous) empties the queue and drops any pending
// result; the store contents are not cleared and need no clearing pass.
// While the receiver stalls, the result register holds its item and s_ready
// drops, so no further item is taken until the result slot frees.
module ring_buffer_deque
    import rbd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    ctrl_cmd_t  cmd;
    dp_status_t dp_status;

    rbd_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    rbd_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_item    (s_item),
        .m_item    (m_item),
        .dp_status (dp_status)
    );

endmodule

[bench/tb_ring_buffer_deque.sv]
// Testbench for the ring buffer deque: shadow deque checks every result item.
module tb_ring_buffer_deque;
    import rbd_pkg::*;

    localparam logic [OP_W-1:0] OP_QUERY    = 3'd4;
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 150;
    localparam int TAIL_CYCLES  = 20;
    localparam int EVEN_ITEMS   = 150;
    localparam int FILL_CHUNK   = 300;
    localparam int FULL_EXTRA   = 40;
    localparam int DRAIN_ITEMS  = 100;
    localparam int MAX_PRINTED  = 100;

    typedef enum {MIX_EVEN, MIX_FILL, MIX_DRAIN} op_mix_t;

    class deque_tracker;
        logic signed [DATA_W-1:0] slots [CAPACITY];
        logic [PTR_W-1:0]         head_ptr;
        logic [PTR_W-1:0]         tail_ptr;
        int                       depth_now;
        out_item_t                due_results [$];
        int                       errors;

        function new();
            head_ptr  = '0;
            tail_ptr  = '0;
            depth_now = 0;
            errors    = 0;
        endfunction

        function logic [PTR_W-1:0] ptr_up(logic [PTR_W-1:0] p);
            return (int'(p) + 1 >= CAPACITY) ? '0 : p + 1'b1;
        endfunction

        function logic [PTR_W-1:0] ptr_down(logic [PTR_W-1:0] p);
            return (p == '0) ? PTR_W'(CAPACITY - 1) : p - 1'b1;
        endfunction

        function void take_item(in_item_t it);
            out_item_t r;
            r.popped_value = NEG_ONE;
            r.status       = STATUS_OK;
            case (it.op)
                OP_PUSH_FRONT, OP_PUSH_BACK: begin
                    if (depth_now >= CAPACITY) begin
                        r.status = STATUS_FULL;
                    end else if (it.op == OP_PUSH_FRONT) begin
                        head_ptr = ptr_down(head_ptr);
                        slots[head_ptr] = it.push_value;
                        depth_now++;
                    end else begin
                        slots[tail_ptr] = it.push_value;
                        tail_ptr = ptr_up(tail_ptr);
                        depth_now++;
                    end
                end
                OP_POP_FRONT, OP_POP_BACK: begin
                    if (depth_now == 0) begin
                        r.status = STATUS_EMPTY;
                    end else if (it.op == OP_POP_FRONT) begin
                        r.popped_value = slots[head_ptr];
                        head_ptr = ptr_up(head_ptr);
                        depth_now--;
                    end else begin
                        tail_ptr = ptr_down(tail_ptr);
                        r.popped_value = slots[tail_ptr];
                        depth_now--;
                    end
                end
                default: begin
                end
            endcase
            r.count       = COUNT_W'(depth_now);
            r.is_empty    = (depth_now == 0);
            r.front_value = (depth_now == 0) ? NEG_ONE : slots[head_ptr];
            r.back_value  = (depth_now == 0) ? NEG_ONE : slots[ptr_down(tail_ptr)];
            due_results = {due_results, r};
        endfunction

        task report(string msg);
            errors++;
            if (errors <= MAX_PRINTED) begin
                $display("mismatch at %0t: %s", $realtime, msg);
            end
        endtask

        task match_result(out_item_t got);
            out_item_t want;
            if (due_results.size() == 0) begin
                report("result item with none awaited");
                return;
            end
            want = due_results[0];
            due_results.delete(0);
            if (got.popped_value !== want.popped_value) begin
                report($sformatf("popped_value %0d, want %0d",
                                 got.popped_value, want.popped_value));
            end
            if (got.status !== want.status) begin
                report($sformatf("status %0d, want %0d", got.status, want.status));
            end
            if (got.count !== want.count) begin
                report($sformatf("count %0d, want %0d", got.count, want.count));
            end
            if (got.is_empty !== want.is_empty) begin
                report($sformatf("is_empty %0b, want %0b", got.is_empty, want.is_empty));
            end
            if (got.front_value !== want.front_value) begin
                report($sformatf("front_value %0d, want %0d",
                                 got.front_value, want.front_value));
            end
            if (got.back_value !== want.back_value) begin
                report($sformatf("back_value %0d, want %0d",
                                 got.back_value, want.back_value));
            end
        endtask
    endclass

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;

    deque_tracker shadow;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    logic         hold_req = 1'b0;
    int           cycles = 0;

    ring_buffer_deque i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("tb_ring_buffer_deque NOT OK");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            shadow.match_result(m_item);
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic send_item(in_item_t it);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        shadow.take_item(it);
    endtask

    task automatic send_op(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] value);
        in_item_t it;
        it.op         = op;
        it.push_value = value;
        send_item(it);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (shadow.due_results.size() != 0) @(posedge aclk);
    endtask

    function automatic in_item_t random_item(op_mix_t mix);
        in_item_t    it;
        int unsigned r;
        r = $urandom_range(99);
        it.push_value = $urandom;
        case (mix)
            MIX_EVEN: begin
                if (r < 22)      it.op = OP_PUSH_FRONT;
                else if (r < 44) it.op = OP_PUSH_BACK;
                else if (r < 66) it.op = OP_POP_FRONT;
                else if (r < 88) it.op = OP_POP_BACK;
                else if (r < 95) it.op = OP_QUERY;
                else             it.op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            end
            MIX_FILL: begin
                if (r < 47)      it.op = OP_PUSH_FRONT;
                else if (r < 94) it.op = OP_PUSH_BACK;
                else if (r < 96) it.op = OP_POP_FRONT;
                else if (r < 98) it.op = OP_POP_BACK;
                else if (r < 99) it.op = OP_QUERY;
                else             it.op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            end
            default: begin
                if (r < 3)       it.op = OP_PUSH_FRONT;
                else if (r < 6)  it.op = OP_PUSH_BACK;
                else if (r < 51) it.op = OP_POP_FRONT;
                else if (r < 96) it.op = OP_POP_BACK;
                else             it.op = OP_QUERY;
            end
        endcase
        return it;
    endfunction

    initial begin
        int n;
        int at_full;
        s_valid = 1'b0;
        s_item  = '0;
        aresetn = 1'b0;
        shadow  = new();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty queue, spare codes, extremes, head wrap below zero
        set_idling(0, 0);
        send_op(OP_QUERY, 32'sh0000_1234);
        send_op(OP_POP_FRONT, 32'sh7FFF_FFFF);
        send_op(OP_POP_BACK, 32'sh8000_0000);
        send_op(OP_SPARE_LO, 32'sh5555_5555);
        send_op(OP_W'(OP_SPARE_LO + 1), NEG_ONE);
        send_op(OP_SPARE_HI, 32'shAAAA_AAAA);
        send_op(OP_PUSH_FRONT, 32'sh7FFF_FFFF);
        send_op(OP_PUSH_BACK, 32'sh8000_0000);
        send_op(OP_PUSH_FRONT, NEG_ONE);
        send_op(OP_PUSH_BACK, 32'sh0000_0000);
        send_op(OP_QUERY, NEG_ONE);
        send_op(OP_POP_BACK, 32'sh0000_0000);
        send_op(OP_POP_FRONT, 32'sh0000_0000);
        send_op(OP_POP_FRONT, 32'sh0000_0000);
        send_op(OP_POP_BACK, 32'sh0000_0000);
        send_op(OP_POP_FRONT, 32'sh0000_0000);
        send_op(OP_PUSH_BACK, 32'sh5555_5555);
        send_op(OP_PUSH_FRONT, 32'shAAAA_AAAA);
        send_op(OP_POP_FRONT, NEG_ONE);
        send_op(OP_POP_BACK, NEG_ONE);
        send_op(OP_PUSH_FRONT, 32'sh0000_0001);
        send_op(OP_POP_BACK, 32'sh0000_0000);
        wait_drained();

        // balanced ops, no idling, opened by a long receiver hold-off
        hold_req = 1'b1;
        for (n = 0; n < EVEN_ITEMS; n++) begin
            send_item(random_item(MIX_EVEN));
        end
        wait_drained();

        // push-heavy until full, then keep pushing against the full queue
        n = 0;
        at_full = 0;
        while (at_full < FULL_EXTRA) begin
            if (n % FILL_CHUNK == 0) begin
                case ((n / FILL_CHUNK) % 3)
                    0:       set_idling(67, 0);
                    1:       set_idling(0, 67);
                    default: set_idling(22, 22);
                endcase
            end
            send_item(random_item(MIX_FILL));
            n++;
            if (shadow.depth_now >= CAPACITY) begin
                at_full++;
            end
        end
        wait_drained();

        set_idling(0, 0);
        for (n = 0; n < DRAIN_ITEMS; n++) begin
            send_item(random_item(MIX_DRAIN));
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (shadow.errors == 0) begin
            $display("tb_ring_buffer_deque OK");
        end else begin
            $display("tb_ring_buffer_deque NOT OK");
        end
        $finish;
    end

endmodule
